[rtl/sfp_pkg.sv]
package sfp_pkg;

    // Frame format
    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] CODE_LIMIT = 8'hFF;
    localparam int         MAX_PAYLOAD = 32;
    localparam int         LEN_W       = 6;

    // Function codes that update held values
    localparam logic [7:0] CODE_DIST = 8'hF0;
    localparam logic [7:0] CODE_FLAG = 8'hF2;
    localparam logic [7:0] CODE_STEP = 8'hF3;

    // A completed frame, handed from the parser to the dispatch stage.
    typedef struct packed {
        logic             valid;
        logic [7:0]       code;
        logic [LEN_W-1:0] length;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
    } t_frame_done;

endpackage

[rtl/sfp_if.sv]
// Received byte channel.
interface sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parsed frame result channel.
interface sfp_result_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                frame_code;
    logic [sfp_pkg::LEN_W-1:0] payload_length;
    logic [15:0]               word_value;
    logic [15:0]               distance_value;
    logic [7:0]                flag_value;
    logic [7:0]                step_value;

    modport source (
        output valid, output frame_code, output payload_length, output word_value,
        output distance_value, output flag_value, output step_value, input ready
    );
    modport sink (
        input valid, input frame_code, input payload_length, input word_value,
        input distance_value, input flag_value, input step_value, output ready
    );
endinterface

[rtl/sfp_parser.sv]
module sfp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_take,
    output sfp_pkg::t_frame_done o_done
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_CODE    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_TRAILER = 3'd5;

    logic                      r_in_valid, n_in_valid;
    logic [7:0]                r_in_byte,  n_in_byte;
    logic [2:0]                r_phase,    n_phase;
    logic [sfp_pkg::LEN_W-1:0] r_left,     n_left;
    logic [sfp_pkg::LEN_W-1:0] r_taken,    n_taken;
    logic [7:0]                r_code,     n_code;
    logic [sfp_pkg::LEN_W-1:0] r_length,   n_length;
    logic [7:0]                r_first,    n_first;
    logic [7:0]                r_second,   n_second;
    logic                      proc;
    logic                      keep;

    // The registered byte is worked on once the result side has room.
    assign proc    = r_in_valid && i_take;
    assign o_ready = !r_in_valid || proc;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (o_ready) begin
            n_in_valid = i_valid;
            n_in_byte  = i_byte;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_taken  = r_taken;
        n_code   = r_code;
        n_length = r_length;
        keep     = 1'b0;
        o_done   = '0;
        if (proc) begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = (r_in_byte == sfp_pkg::HDR_BYTE) ? PH_HDR1 : PH_IDLE;
                end
                PH_HDR1: begin
                    n_phase = (r_in_byte == sfp_pkg::HDR_BYTE) ? PH_CODE : PH_IDLE;
                end
                PH_CODE: begin
                    if (r_in_byte < sfp_pkg::CODE_LIMIT) begin
                        n_code  = r_in_byte;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    if (r_in_byte <= 8'(sfp_pkg::MAX_PAYLOAD)) begin
                        n_length = r_in_byte[sfp_pkg::LEN_W-1:0];
                        n_left   = r_in_byte[sfp_pkg::LEN_W-1:0];
                        n_taken  = '0;
                        n_phase  = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_left != '0) begin
                        n_left  = r_left - 1'b1;
                        keep    = 1'b1;
                        n_taken = r_taken + 1'b1;
                        n_phase = (r_left == sfp_pkg::LEN_W'(1)) ? PH_TRAILER : PH_PAYLOAD;
                    end else begin
                        // Zero-length frame: dropped on this byte.
                        n_phase = PH_IDLE;
                    end
                end
                PH_TRAILER: begin
                    keep         = 1'b1;
                    n_phase      = PH_IDLE;
                    o_done.valid = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Frame bytes 4 and 5 are the first two bytes after the length.
        n_first  = r_first;
        n_second = r_second;
        if (keep && r_taken == '0) begin
            n_first = r_in_byte;
        end
        if (keep && r_taken == sfp_pkg::LEN_W'(1)) begin
            n_second = r_in_byte;
        end

        o_done.code        = r_code;
        o_done.length      = r_length;
        o_done.first_byte  = n_first;
        o_done.second_byte = n_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_left     <= '0;
            r_taken    <= '0;
            r_code     <= '0;
            r_length   <= '0;
            r_first    <= '0;
            r_second   <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_taken    <= n_taken;
            r_code     <= n_code;
            r_length   <= n_length;
            r_first    <= n_first;
            r_second   <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
    end

endmodule

[rtl/sfp_dispatch.sv]
module sfp_dispatch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfp_pkg::t_frame_done i_done,
    output logic                 o_take,
    sfp_result_if.source         o_res
);

    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_code;
    logic [sfp_pkg::LEN_W-1:0] r_length;
    logic [15:0]               r_word;
    logic [15:0]               r_dist, n_dist;
    logic [7:0]                r_flag, n_flag;
    logic [7:0]                r_step, n_step;
    logic [15:0]               word;

    // Room for a new result when the register is empty or being drained.
    assign o_take = !r_out_valid || o_res.ready;
    assign word   = {i_done.first_byte, i_done.second_byte};

    always_comb begin
        n_dist      = r_dist;
        n_flag      = r_flag;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_res.ready;
        if (i_done.valid) begin
            n_out_valid = 1'b1;
            if (i_done.code == sfp_pkg::CODE_DIST) begin
                n_dist = word;
            end else if (i_done.code == sfp_pkg::CODE_FLAG) begin
                n_flag = i_done.first_byte;
            end else if (i_done.code == sfp_pkg::CODE_STEP) begin
                n_step = word[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_dist      <= '0;
            r_flag      <= '0;
            r_step      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_dist      <= n_dist;
            r_flag      <= n_flag;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_done.valid) begin
            r_code   <= i_done.code;
            r_length <= i_done.length;
            r_word   <= word;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_code     = r_code;
    assign o_res.payload_length = r_length;
    assign o_res.word_value     = r_word;
    assign o_res.distance_value = r_dist;
    assign o_res.flag_value     = r_flag;
    assign o_res.step_value     = r_step;

endmodule

[rtl/serial_frame_parser_dispatch_top.sv]
// Serial frame parser. Each word on i_rx is one received byte. Frames have the
// form 0xAA 0xAA, code (below 0xFF), length (0 to 32), payload, and one trailer
// byte that is never checked. A byte that breaks the form returns the parser to
// idle and is consumed; it is not looked at again as a header start. A frame
// of zero length is dropped on the byte after its length. On the trailer byte
// one word leaves on o_res carrying the code, the length, frame bytes 4 and 5
// joined into a 16-bit word (with length one, byte 5 is the trailer), and the
// held distance, flag and step values after this frame's update: code 0xF0
// loads the distance from the word, 0xF2 loads the flag from byte 4, and 0xF3
// loads the step from byte 5. Throughput is one byte per clock. A byte is held
// in the input register and is parsed on its way into the result register, so
// a result is valid on o_res once its trailer has passed both registers. Input
// flow stalls only while a finished result waits on o_res.ready.
module serial_frame_parser_dispatch_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfp_byte_if.sink     i_rx,
    sfp_result_if.source o_res
);

    sfp_pkg::t_frame_done done;
    logic                 take;

    // Input register and frame state machine.
    sfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (i_rx.ready),
        .i_byte  (i_rx.rx_byte),
        .i_take  (take),
        .o_done  (done)
    );

    // Held values and the result register.
    sfp_dispatch u_dispatch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (done),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule
